FILE: hdl/vau_pkg.sv
// vau_pkg: shared types for the three-component vector arithmetic unit
// action codes, the result word and the record carried down the pipeline
// no dependencies
package vau_pkg;

   typedef enum logic [3:0] {
      ACT_ADD       = 4'd0,
      ACT_SUB       = 4'd1,
      ACT_SCALE     = 4'd2,
      ACT_DIVIDE    = 4'd3,
      ACT_DOT       = 4'd4,
      ACT_CROSS     = 4'd5,
      ACT_LENGTH    = 4'd6,
      ACT_NORMALIZE = 4'd7,
      ACT_COMPARE   = 4'd8
   } action_type;

   // result word, fields as they leave the block
   typedef struct packed {
      logic [31:0] res_x;
      logic [31:0] res_y;
      logic [31:0] res_z;
      logic [31:0] res_scalar;
      logic        equal;
      logic        error;
   } result_type;

   // what travels with an item through the root stages
   typedef struct packed {
      action_type       act;
      logic [2:0][31:0] a;
      logic [31:0]      s;
      result_type       r;
   } pass_type;

endpackage

FILE: hdl/vector3_arithmetic_unit.sv
// vector3_arithmetic_unit: pipelined signed fixed-point vector alu
// uses vau_pkg for the action codes, the result word and the pipeline record
// single module, no submodules
//
// One word enters per clock and one result word leaves per clock, in order,
// while no result is held. Every word, whatever its action, runs the same
// pipeline to the rsp side: three stages of operand select, multiply and sum,
// 32 stages of bit-per-stage square root, one divisor prep stage,
// 32 + FRACTION_BITS stages of bit-per-stage divide (three lanes), and the
// output register. The square root and the divider length set the pipeline depth.
// The whole pipeline holds while a result waits on rsp_tready, and
// req_tready is low only then. Values are two's complement with
// FRACTION_BITS fraction bits (Q16.16 by default); results saturate to
// VALUE_WIDTH bits and are then carried in 32-bit fields. A divide by zero
// gives a zero vector with error set; normalize of a zero vector gives zero;
// unknown action codes give an all-zero result.
module vector3_arithmetic_unit #(
   parameter int VALUE_WIDTH   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in (32 bits each, from bit 0 up)
   input  logic [223:0] req_tdata,
   // action
   input  logic [3:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // res_x, res_y, res_z, res_scalar (32 bits each, from bit 0 up)
   output logic [127:0] rsp_tdata,
   // equal, error (from bit 0 up)
   output logic [1:0]   rsp_tuser
);

   // wide signed working width: holds three 64-bit products without overflow
   localparam int SW = 68;
   // divider dividend width: |a| shifted up by the fraction bits
   localparam int DW = 32 + FRACTION_BITS;
   localparam int RT = 32;  // square root steps
   localparam logic signed [SW-1:0] VMAX =
      ({{(SW-1){1'b0}}, 1'b1} << (VALUE_WIDTH - 1)) - 1;
   localparam logic signed [SW-1:0] VMIN = -VMAX - 1;

   function automatic logic [31:0] sat32(input logic signed [SW-1:0] v);
      logic [31:0] r;
      if (v > VMAX) r = VMAX[31:0];
      else if (v < VMIN) r = VMIN[31:0];
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [SW-1:0] ext64(input logic [63:0] v);
      return {{(SW-64){v[63]}}, v};
   endfunction

   function automatic logic signed [SW-1:0] ext32(input logic [31:0] v);
      return {{(SW-32){v[31]}}, v};
   endfunction

   // global advance: the pipeline moves unless a result is held
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // ---------------- stage 1: operand select ----------------
   logic                  s1_vld_ff;
   vau_pkg::action_type   s1_act_ff;
   logic [2:0][31:0]      s1_a_ff, s1_b_ff;
   logic [31:0]           s1_s_ff;
   logic signed [31:0]    s1_op1_ff [6];
   logic signed [31:0]    s1_op2_ff [6];
   logic signed [31:0]    s1_op1_in [6];
   logic signed [31:0]    s1_op2_in [6];
   logic [2:0][31:0]      in_a, in_b;
   vau_pkg::action_type   in_act;

   assign in_act = vau_pkg::action_type'(req_tuser);
   assign in_a   = req_tdata[95:0];
   assign in_b   = req_tdata[191:96];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // cross pairs: x = a1*b2 - a2*b1 and rotations
         if (in_act == vau_pkg::ACT_CROSS) begin
            s1_op1_in[i] = in_a[(i+1)%3];
            s1_op2_in[i] = in_b[(i+2)%3];
         end else begin
            s1_op1_in[i] = in_a[i];
            case (in_act)
               vau_pkg::ACT_SCALE: s1_op2_in[i] = req_tdata[223:192];
               vau_pkg::ACT_DOT:   s1_op2_in[i] = in_b[i];
               default:            s1_op2_in[i] = in_a[i];  // squares for length
            endcase
         end
         s1_op1_in[i+3] = in_a[(i+2)%3];
         s1_op2_in[i+3] = in_b[(i+1)%3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_tvalid;
      end
      if (en) begin
         s1_act_ff <= in_act;
         s1_a_ff   <= in_a;
         s1_b_ff   <= in_b;
         s1_s_ff   <= req_tdata[223:192];
         for (int j = 0; j < 6; j++) begin
            s1_op1_ff[j] <= s1_op1_in[j];
            s1_op2_ff[j] <= s1_op2_in[j];
         end
      end
   end

   // ---------------- stage 2: multiply, add/sub, compare ----------------
   logic                  s2_vld_ff;
   vau_pkg::action_type   s2_act_ff;
   logic [2:0][31:0]      s2_a_ff;
   logic [31:0]           s2_s_ff;
   logic signed [63:0]    s2_m_ff [6];
   logic [2:0][31:0]      s2_as_ff, s2_as_in;
   logic                  s2_eq_ff, s2_eq_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (s1_act_ff == vau_pkg::ACT_SUB)
            s2_as_in[i] = sat32(ext32(s1_a_ff[i]) - ext32(s1_b_ff[i]));
         else
            s2_as_in[i] = sat32(ext32(s1_a_ff[i]) + ext32(s1_b_ff[i]));
      end
      s2_eq_in = (s1_a_ff == s1_b_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (en) begin
         s2_act_ff <= s1_act_ff;
         s2_a_ff   <= s1_a_ff;
         s2_s_ff   <= s1_s_ff;
         s2_as_ff  <= s2_as_in;
         s2_eq_ff  <= s2_eq_in;
         for (int j = 0; j < 6; j++) s2_m_ff[j] <= s1_op1_ff[j] * s1_op2_ff[j];
      end
   end

   // ---------------- stage 3: sums, floor shift, base result ----------------
   logic signed [SW-1:0]  s3_dsum;
   logic signed [SW-1:0]  s3_t [3];
   vau_pkg::pass_type     s3_pass_in;

   always_comb begin
      s3_dsum = ext64(s2_m_ff[0]) + ext64(s2_m_ff[1]) + ext64(s2_m_ff[2]);
      for (int i = 0; i < 3; i++) begin
         if (s2_act_ff == vau_pkg::ACT_CROSS)
            s3_t[i] = ext64(s2_m_ff[i]) - ext64(s2_m_ff[i+3]);
         else
            s3_t[i] = ext64(s2_m_ff[i]);
      end
      s3_pass_in.act = s2_act_ff;
      s3_pass_in.a   = s2_a_ff;
      s3_pass_in.s   = s2_s_ff;
      s3_pass_in.r   = '0;
      case (s2_act_ff)
         vau_pkg::ACT_ADD, vau_pkg::ACT_SUB: begin
            s3_pass_in.r.res_x = s2_as_ff[0];
            s3_pass_in.r.res_y = s2_as_ff[1];
            s3_pass_in.r.res_z = s2_as_ff[2];
         end
         vau_pkg::ACT_SCALE, vau_pkg::ACT_CROSS: begin
            s3_pass_in.r.res_x = sat32(s3_t[0] >>> FRACTION_BITS);
            s3_pass_in.r.res_y = sat32(s3_t[1] >>> FRACTION_BITS);
            s3_pass_in.r.res_z = sat32(s3_t[2] >>> FRACTION_BITS);
         end
         vau_pkg::ACT_DOT: s3_pass_in.r.res_scalar = sat32(s3_dsum >>> FRACTION_BITS);
         vau_pkg::ACT_COMPARE: s3_pass_in.r.equal = s2_eq_ff;
         default: ;
      endcase
   end

   // ---------------- square root, one result bit per stage ----------------
   // index 0 is stage 3's register
   logic                  sq_vld_ff  [RT+1];
   vau_pkg::pass_type     sq_pass_ff [RT+1];
   logic [63:0]           sq_v_ff    [RT+1];
   logic [33:0]           sq_rem_ff  [RT+1];
   logic [31:0]           sq_root_ff [RT+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else if (en) begin
         sq_vld_ff[0] <= s2_vld_ff;
      end
      if (en) begin
         sq_pass_ff[0] <= s3_pass_in;
         sq_v_ff[0]    <= s3_dsum[63:0];
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= RT; k++) begin : g_sqrt
      logic [35:0] rem_sh, trial, diff;
      logic        ge;
      logic [33:0] rem_in;
      logic [31:0] root_in;
      always_comb begin
         rem_sh  = {sq_rem_ff[k-1], sq_v_ff[k-1][63:62]};
         trial   = {2'b00, sq_root_ff[k-1], 2'b01};
         diff    = rem_sh - trial;
         ge      = rem_sh >= trial;
         rem_in  = ge ? diff[33:0] : rem_sh[33:0];
         root_in = {sq_root_ff[k-1][30:0], ge};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k] <= 1'b0;
         end else if (en) begin
            sq_vld_ff[k] <= sq_vld_ff[k-1];
         end
         if (en) begin
            sq_pass_ff[k] <= sq_pass_ff[k-1];
            sq_v_ff[k]    <= {sq_v_ff[k-1][61:0], 2'b00};
            sq_rem_ff[k]  <= rem_in;
            sq_root_ff[k] <= root_in;
         end
      end
   end

   // ---------------- divisor prep ----------------
   vau_pkg::pass_type     pp;
   logic [31:0]           pp_len, pp_abs_s, pp_d;
   logic                  pp_div, pp_norm;
   logic [2:0][DW-1:0]    pp_mag;
   logic [2:0]            pp_neg;
   vau_pkg::result_type   pp_r;

   always_comb begin
      pp       = sq_pass_ff[RT];
      pp_len   = sq_root_ff[RT];
      pp_div   = (pp.act == vau_pkg::ACT_DIVIDE);
      pp_norm  = (pp.act == vau_pkg::ACT_NORMALIZE);
      pp_abs_s = pp.s[31] ? (32'd0 - pp.s) : pp.s;
      pp_d     = pp_div ? pp_abs_s : pp_len;
      for (int i = 0; i < 3; i++) begin
         pp_mag[i] = DW'(pp.a[i][31] ? (32'd0 - pp.a[i]) : pp.a[i]) << FRACTION_BITS;
         pp_neg[i] = pp.a[i][31] ^ (pp_div & pp.s[31]);
      end
      pp_r = pp.r;
      if (pp_div && pp.s == '0) pp_r.error = 1'b1;
      if (pp.act == vau_pkg::ACT_LENGTH)
         pp_r.res_scalar = sat32({{(SW-32){1'b0}}, pp_len});
   end

   // ---------------- divider, one quotient bit per stage, three lanes ----------------
   logic                  dv_vld_ff  [DW+1];
   vau_pkg::result_type   dv_r_ff    [DW+1];
   logic [31:0]           dv_d_ff    [DW+1];
   logic [2:0]            dv_neg_ff  [DW+1];
   logic                  dv_use_ff  [DW+1];
   logic [2:0][31:0]      dv_rem_ff  [DW+1];
   logic [2:0][DW-1:0]    dv_q_ff    [DW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (en) begin
         dv_vld_ff[0] <= sq_vld_ff[RT];
      end
      if (en) begin
         dv_r_ff[0]   <= pp_r;
         dv_d_ff[0]   <= pp_d;
         dv_neg_ff[0] <= pp_neg;
         dv_use_ff[0] <= (pp_div || pp_norm) && (pp_d != '0);
         dv_rem_ff[0] <= '0;
         dv_q_ff[0]   <= pp_mag;
      end
   end

   for (genvar k = 1; k <= DW; k++) begin : g_div
      logic [2:0][31:0]   rem_in;
      logic [2:0][DW-1:0] q_in;
      logic [32:0]        rem_sh [3];
      logic [32:0]        diff   [3];
      logic [2:0]         ge;
      always_comb begin
         for (int j = 0; j < 3; j++) begin
            rem_sh[j] = {dv_rem_ff[k-1][j], dv_q_ff[k-1][j][DW-1]};
            diff[j]   = rem_sh[j] - {1'b0, dv_d_ff[k-1]};
            ge[j]     = rem_sh[j] >= {1'b0, dv_d_ff[k-1]};
            rem_in[j] = ge[j] ? diff[j][31:0] : rem_sh[j][31:0];
            q_in[j]   = {dv_q_ff[k-1][j][DW-2:0], ge[j]};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k] <= 1'b0;
         end else if (en) begin
            dv_vld_ff[k] <= dv_vld_ff[k-1];
         end
         if (en) begin
            dv_r_ff[k]   <= dv_r_ff[k-1];
            dv_d_ff[k]   <= dv_d_ff[k-1];
            dv_neg_ff[k] <= dv_neg_ff[k-1];
            dv_use_ff[k] <= dv_use_ff[k-1];
            dv_rem_ff[k] <= rem_in;
            dv_q_ff[k]   <= q_in;
         end
      end
   end

   // ---------------- output register ----------------
   logic                  out_vld_ff;
   vau_pkg::result_type   out_res_ff, out_res_in;
   logic [2:0][31:0]      qv;
   logic signed [SW-1:0]  qs;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         qs    = {{(SW-DW){1'b0}}, dv_q_ff[DW][j]};
         qv[j] = sat32(dv_neg_ff[DW][j] ? -qs : qs);
      end
      out_res_in = dv_r_ff[DW];
      if (dv_use_ff[DW]) begin
         out_res_in.res_x = qv[0];
         out_res_in.res_y = qv[1];
         out_res_in.res_z = qv[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= dv_vld_ff[DW];
      end
      if (en) begin
         out_res_ff <= out_res_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_res_ff.res_scalar, out_res_ff.res_z,
                        out_res_ff.res_y, out_res_ff.res_x};
   assign rsp_tuser  = {out_res_ff.error, out_res_ff.equal};

   // ---------------- checks ----------------
   // a divide by zero leaves the vector at zero
   a_err_zero_vec: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata[95:0] == '0)
      else $error("error word carries a nonzero vector");

   // equal only comes from compare, which sets nothing else
   a_eq_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0 && !rsp_tuser[1])
      else $error("equal word carries other fields");

   // the pipeline only holds for a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a held result");

endmodule
